@@ rtl/mstb_pkg.sv @@
// Package for the multi-slot token bucket: sizes, command and status codes,
// beat structs and the back-end state type. No dependencies.
`timescale 1ns / 1ps

package mstb_pkg;

    localparam int SLOTS      = 16;
    localparam int SLOT_BITS  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int COUNT_BITS = 16;
    localparam int WIDE_BITS  = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;
    localparam logic [31:0] COUNT_MAX = 32'((64'd1 << COUNT_BITS) - 64'd1);
    localparam int QUEUE_DEPTH = 2;

    // command kinds on the input beat
    localparam logic [2:0] KIND_TICK   = 3'd0;
    localparam logic [2:0] KIND_OPEN   = 3'd1;
    localparam logic [2:0] KIND_FETCH  = 3'd2;
    localparam logic [2:0] KIND_RETURN = 3'd3;
    localparam logic [2:0] KIND_CLOSE  = 3'd4;

    // result status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_AMOUNT = 3'd1;
    localparam logic [2:0] ST_FULL       = 3'd2;
    localparam logic [2:0] ST_EMPTY      = 3'd3;
    localparam logic [2:0] ST_NOT_OPEN   = 3'd4;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  slot;
        logic [15:0] amount;
        logic [15:0] rate;
        logic [15:0] bucket_cap;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] value;
    } result_t;

    // classified operation handed from front to back
    typedef enum logic [2:0] {
        OP_NONE,
        OP_TICK,
        OP_OPEN,
        OP_FETCH,
        OP_RETURN,
        OP_CLOSE,
        OP_BAD_AMOUNT,
        OP_NOT_OPEN
    } op_kind_t;

    typedef struct packed {
        op_kind_t               op;
        logic [SLOT_BITS-1:0]   slot;
        logic [15:0]            amount;
        logic [15:0]            rate;
        logic [COUNT_BITS-1:0]  cap;
    } op_t;

    typedef struct packed {
        logic [15:0]           rate;
        logic [COUNT_BITS-1:0] cap;
        logic [COUNT_BITS-1:0] tokens;
    } entry_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_EXEC
    } bk_state_t;

endpackage

@@ rtl/mstb_front.sv @@
// Front end: accepts command beats and classifies them into queue entries.
// Depends on mstb_pkg.
`timescale 1ns / 1ps

module mstb_front import mstb_pkg::*;
(
    input  logic start,
    input  logic busy,
    input  cmd_t cmd,
    output logic push,
    output op_t  entry
);

    logic slot_in_range;

    assign push          = start & ~busy;
    assign slot_in_range = (32'(cmd.slot) < 32'(SLOTS));

    always_comb
    begin
        entry.slot   = SLOT_BITS'(cmd.slot);
        entry.amount = cmd.amount;
        entry.rate   = cmd.rate;
        // cap is clipped to the largest token count
        if (32'(cmd.bucket_cap) > COUNT_MAX)
        begin
            entry.cap = COUNT_BITS'(COUNT_MAX);
        end
        else
        begin
            entry.cap = COUNT_BITS'(cmd.bucket_cap);
        end
        case (cmd.kind)
            KIND_TICK:   entry.op = OP_TICK;
            KIND_OPEN:   entry.op = OP_OPEN;
            KIND_FETCH:
            begin
                // zero amount is reported before the slot is looked at
                if (cmd.amount == 16'd0)
                    entry.op = OP_BAD_AMOUNT;
                else if (!slot_in_range)
                    entry.op = OP_NOT_OPEN;
                else
                    entry.op = OP_FETCH;
            end
            KIND_RETURN: entry.op = slot_in_range ? OP_RETURN : OP_NOT_OPEN;
            KIND_CLOSE:  entry.op = slot_in_range ? OP_CLOSE : OP_NOT_OPEN;
            default:     entry.op = OP_NONE;
        endcase
    end

endmodule

@@ rtl/mstb_queue.sv @@
// Short FIFO of classified operations between front and back end.
// Depends on mstb_pkg.
`timescale 1ns / 1ps

module mstb_queue import mstb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  push_entry,
    input  logic pop,
    output op_t  head,
    output logic full,
    output logic empty
);

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    op_t                 q_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                do_push, do_pop;

    assign full    = (32'(count_reg) == 32'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;
    assign head    = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (32'(wr_ptr_reg) == 32'(QUEUE_DEPTH - 1)) ? '0
                                                                    : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (32'(rd_ptr_reg) == 32'(QUEUE_DEPTH - 1)) ? '0
                                                                    : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            q_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

@@ rtl/mstb_back.sv @@
// Back end: slot table (open flags plus rate/cap/token memory) and the
// read-then-write sequencer that carries out each operation. Depends on mstb_pkg.
`timescale 1ns / 1ps

module mstb_back import mstb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    q_empty,
    input  op_t     q_head,
    output logic    q_pop,
    output logic    done,
    output result_t result
);

    bk_state_t            state_reg, state_next;
    op_t                  cur_reg, cur_next;
    logic [SLOT_BITS-1:0] idx_reg, idx_next;
    logic [SLOTS-1:0]     open_reg, open_next;
    logic                 done_reg, done_next;
    result_t              result_reg, result_next;

    entry_t               mem [SLOTS];
    entry_t               rd_data_reg;
    logic                 wr_en;
    logic [SLOT_BITS-1:0] wr_addr;
    entry_t               wr_data;

    logic                 finish;
    logic                 table_full;
    logic [SLOT_BITS-1:0] free_idx;
    logic [WIDE_BITS-1:0] sum;
    logic [WIDE_BITS-1:0] grant;

    // lowest free slot
    always_comb
    begin
        free_idx   = '0;
        table_full = &open_reg;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!open_reg[i])
                free_idx = SLOT_BITS'(i);
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cur_next    = cur_reg;
        idx_next    = idx_reg;
        open_next   = open_reg;
        q_pop       = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = idx_reg;
        wr_data     = rd_data_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        finish      = 1'b0;
        sum         = '0;
        grant       = '0;

        case (state_reg)
            BK_IDLE: ;
            BK_READ: state_next = BK_EXEC;
            BK_EXEC:
            begin
                finish             = 1'b1;
                result_next.status = ST_OK;
                result_next.value  = 16'd0;
                case (cur_reg.op)
                    OP_TICK:
                    begin
                        if (open_reg[idx_reg])
                        begin
                            sum   = WIDE_BITS'(rd_data_reg.tokens) + WIDE_BITS'(rd_data_reg.rate);
                            wr_en = 1'b1;
                            wr_data.tokens = (sum > WIDE_BITS'(rd_data_reg.cap))
                                           ? rd_data_reg.cap : COUNT_BITS'(sum);
                        end
                        if (32'(idx_reg) != 32'(SLOTS - 1))
                        begin
                            finish     = 1'b0;
                            idx_next   = idx_reg + 1'b1;
                            state_next = BK_READ;
                        end
                    end
                    OP_OPEN:
                    begin
                        if (table_full)
                        begin
                            result_next.status = ST_FULL;
                        end
                        else
                        begin
                            open_next[free_idx] = 1'b1;
                            wr_en               = 1'b1;
                            wr_addr             = free_idx;
                            wr_data.rate        = cur_reg.rate;
                            wr_data.cap         = cur_reg.cap;
                            wr_data.tokens      = '0;
                            result_next.value   = 16'(free_idx);
                        end
                    end
                    OP_FETCH:
                    begin
                        if (!open_reg[cur_reg.slot])
                            result_next.status = ST_NOT_OPEN;
                        else if (rd_data_reg.tokens == '0)
                            result_next.status = ST_EMPTY;
                        else
                        begin
                            grant = (WIDE_BITS'(rd_data_reg.tokens) < WIDE_BITS'(cur_reg.amount))
                                  ? WIDE_BITS'(rd_data_reg.tokens) : WIDE_BITS'(cur_reg.amount);
                            wr_en             = 1'b1;
                            wr_data.tokens    = rd_data_reg.tokens - COUNT_BITS'(grant);
                            result_next.value = 16'(grant);
                        end
                    end
                    OP_RETURN:
                    begin
                        if (!open_reg[cur_reg.slot])
                            result_next.status = ST_NOT_OPEN;
                        else
                        begin
                            sum   = WIDE_BITS'(rd_data_reg.tokens) + WIDE_BITS'(cur_reg.amount);
                            wr_en = 1'b1;
                            wr_data.tokens = (sum > WIDE_BITS'(rd_data_reg.cap))
                                           ? rd_data_reg.cap : COUNT_BITS'(sum);
                            result_next.value = cur_reg.amount;
                        end
                    end
                    OP_CLOSE:
                    begin
                        if (!open_reg[cur_reg.slot])
                            result_next.status = ST_NOT_OPEN;
                        else
                            open_next[cur_reg.slot] = 1'b0;
                    end
                    OP_BAD_AMOUNT: result_next.status = ST_BAD_AMOUNT;
                    OP_NOT_OPEN:   result_next.status = ST_NOT_OPEN;
                    default: ;
                endcase
                if (finish)
                begin
                    done_next  = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase

        // take the next entry straight after a finishing step
        if ((state_reg == BK_IDLE || finish) && !q_empty)
        begin
            q_pop      = 1'b1;
            cur_next   = q_head;
            idx_next   = (q_head.op == OP_TICK) ? '0 : q_head.slot;
            state_next = BK_READ;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            open_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            open_reg  <= open_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        idx_reg     <= idx_next;
        result_reg  <= result_next;
    end

    // slot table memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[idx_reg];
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ rtl/multi_slot_token_bucket_top.sv @@
// Top level of the multi-slot token bucket rate limiter.
// Depends on mstb_pkg, mstb_front, mstb_queue and mstb_back.
`timescale 1ns / 1ps

// Usage
//   Command channel: drive cmd and raise start; the beat is taken at a
//   rising edge where start is high and busy is low. busy is high only
//   while the two-entry command queue is full.
//   Result channel: every command gives one result beat on result, marked
//   by done for exactly one cycle. The receiver cannot stall; it must take
//   each beat in the cycle it appears.
//   Path: with the back end idle, a command passes through the queue,
//   the table read and the execute-and-write step before done rises.
//   Sequencing: open, fetch, return, close and rejected commands each take
//   a read step for the slot table entry and an update step in the back
//   end, as the table has a single read and a single write port. A tick
//   sweeps every slot through those same ports, reading and updating each.
//   Commands queue behind a tick; busy holds the front off when full.
//   Reset (rst_n low, asynchronous): all slots closed, queue emptied, no
//   result pending. The rate, cap and token memory is not cleared; an
//   entry's contents are used only after open has written them.
module multi_slot_token_bucket_top import mstb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  cmd_t    cmd,
    output logic    done,
    output result_t result
);

    logic push;
    op_t  push_entry;
    logic q_pop;
    op_t  q_head;
    logic q_full;
    logic q_empty;

    // classify commands as they arrive
    mstb_front u_front
    (
        .start (start),
        .busy  (q_full),
        .cmd   (cmd),
        .push  (push),
        .entry (push_entry)
    );

    // decouples acceptance from the table sequencer
    mstb_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .head       (q_head),
        .full       (q_full),
        .empty      (q_empty)
    );

    // slot table and read-modify-write sequencer
    mstb_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .done    (done),
        .result  (result)
    );

    assign busy = q_full;

endmodule
